>>> design/bmec_pkg.sv
`default_nettype none
package bmec_pkg;

  localparam int KIND_WIDTH   = 2;
  localparam int SYMBOL_WIDTH = 8;

  localparam logic [KIND_WIDTH-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]   kind;
    logic [SYMBOL_WIDTH-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic is_permutation;
    logic overflowed;
  } out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/bmec_mem.sv
`default_nettype none
module bmec_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 17,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read and write of the same entry on one edge returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> design/bmec_core.sv
`default_nettype none
module bmec_core #(
  parameter int ALPHABET_SIZE = 256,
  parameter int COUNT_WIDTH   = 17,
  localparam int AW = $clog2(ALPHABET_SIZE)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire bmec_pkg::in_t          in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output bmec_pkg::out_t              out_data,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [COUNT_WIDTH-1:0]      mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  wire logic [COUNT_WIDTH-1:0] mem_rdata
);

  localparam logic [COUNT_WIDTH-1:0] MAX_POS = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] MIN_NEG = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic [AW-1:0]          LAST    = AW'(ALPHABET_SIZE - 1);

  bmec_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             chk_r, chk_nxt;
  logic             nz_r, nz_nxt;
  logic             ovf_r, ovf_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_up_r;
  logic [AW-1:0]    s1_addr_r;
  logic             fw_valid_r, fw_valid_nxt;
  logic [AW-1:0]    fw_addr_r;
  logic [COUNT_WIDTH-1:0] fw_val_r;
  logic             out_valid_r, out_valid_nxt;
  bmec_pkg::out_t   out_data_r, out_data_nxt;

  logic                   accept, is_byte, in_range, last, load, nz_all;
  logic                   s1_sat, s1_write;
  logic [COUNT_WIDTH-1:0] cur, upd;

  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, in_data.symbol} < 9'(ALPHABET_SIZE);
  assign is_byte  = (in_data.kind == bmec_pkg::KIND_FIRST) ||
                    (in_data.kind == bmec_pkg::KIND_SECOND);
  assign last     = cnt_r == LAST;

  // previous write is not yet visible in the read data, take it from the bypass
  assign cur    = (fw_valid_r && fw_addr_r == s1_addr_r) ? fw_val_r : mem_rdata;
  assign s1_sat = s1_up_r ? (cur == MAX_POS) : (cur == MIN_NEG);
  assign upd    = s1_up_r ? cur + 1'b1 : cur - 1'b1;
  assign s1_write = s1_valid_r && !s1_sat;

  assign nz_all = nz_r || (chk_r && mem_rdata != '0);
  assign load   = (state_r == bmec_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmec_pkg::ST_CLEAR: if (last) state_nxt = bmec_pkg::ST_IDLE;
      bmec_pkg::ST_IDLE: begin
        if (accept && in_data.kind == bmec_pkg::KIND_FINISH) state_nxt = bmec_pkg::ST_SCAN;
      end
      bmec_pkg::ST_SCAN:  if (last) state_nxt = bmec_pkg::ST_DONE;
      bmec_pkg::ST_DONE:  if (load) state_nxt = bmec_pkg::ST_IDLE;
      default:            state_nxt = bmec_pkg::ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall     = (state_r != bmec_pkg::ST_IDLE);
    cnt_nxt      = '0;
    chk_nxt      = (state_r == bmec_pkg::ST_SCAN);
    nz_nxt       = nz_all;
    ovf_nxt      = ovf_r || s1_sat && s1_valid_r;
    s1_valid_nxt = accept && is_byte && in_range;
    fw_valid_nxt = s1_write;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_raddr    = in_data.symbol[AW-1:0];
    mem_we       = s1_write;
    mem_waddr    = s1_addr_r;
    mem_wdata    = upd;
    case (state_r)
      bmec_pkg::ST_CLEAR, bmec_pkg::ST_SCAN: begin
        // sweep: read the old count and zero the entry on the same edge
        cnt_nxt   = last ? '0 : AW'(cnt_r + 1'b1);
        mem_raddr = cnt_r;
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
      end
      bmec_pkg::ST_DONE: begin
        if (load) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.is_permutation = !nz_all && !ovf_r;
          out_data_nxt.overflowed     = ovf_r;
          nz_nxt                      = 1'b0;
          ovf_nxt                     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmec_pkg::ST_CLEAR;
      cnt_r       <= '0;
      chk_r       <= 1'b0;
      nz_r        <= 1'b0;
      ovf_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_r       <= chk_nxt;
      nz_r        <= nz_nxt;
      ovf_r       <= ovf_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fw_valid_r  <= fw_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_up_r    <= (in_data.kind == bmec_pkg::KIND_FIRST);
    s1_addr_r  <= in_data.symbol[AW-1:0];
    fw_addr_r  <= s1_addr_r;
    fw_val_r   <= upd;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> design/byte_multiset_equality_check_top.sv
// byte multiset equality check: tells whether two byte strings are permutations
// of each other
// input channel: in_valid / in_stall / in_data (kind, symbol). kind first adds one
// to the symbol's signed difference count, kind second subtracts one, kind finish
// asks for the result; the unused kind is taken and ignored, as is a symbol
// outside the alphabet
// byte transfers are taken one per cycle while in_stall is low: each is a
// read-modify-write of the count memory, bypassing the previous cycle's write
// a finish sweeps the whole memory, reading and zeroing one entry a cycle, so
// in_stall stays high through the sweep and until its result is loaded into
// the result register
// output channel: out_valid / out_stall / out_data (is_permutation, overflowed);
// a count that would leave its range saturates and sets the sticky overflow,
// which forces is_permutation low
// the result register holds while out_stall is high; byte transfers keep being
// taken meanwhile, and the next finish waits at the end of its sweep
// reset: a clearing pass zeroes the whole memory, with in_stall high throughout
`default_nettype none
module byte_multiset_equality_check_top #(
  parameter int ALPHABET_SIZE = 256,
  parameter int COUNT_WIDTH   = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bmec_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bmec_pkg::out_t      out_data
);

  localparam int AW = $clog2(ALPHABET_SIZE);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;

  bmec_core #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  bmec_mem #(
    .DEPTH(ALPHABET_SIZE),
    .WIDTH(COUNT_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

>>> design/bmec_checker.sv
`default_nettype none
module bmec_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire bmec_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire bmec_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // overflow always spoils the match
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_permutation && out_data.overflowed))
    else $error("match reported with overflow");

  // clearing pass blocks input right after reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // finish transfer starts the sweep
  a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == bmec_pkg::KIND_FINISH |=> in_stall)
    else $error("input taken during finish sweep");

endmodule

bind byte_multiset_equality_check_top bmec_checker u_chk (.*);
`default_nettype wire
